// File: hw/rtl/klbs_pkg.sv
// Shared constants for the keypoint level budget selector.
// No dependencies.
`default_nettype none
package klbs_pkg;
    localparam int BUF_DEPTH  = 64;
    localparam int IDX_W      = $clog2(BUF_DEPTH);
    localparam int CNT_W      = $clog2(BUF_DEPTH + 1);
    localparam int MAX_LEVELS = 8;
    localparam int LVL_W      = 3;
    localparam int LC_W       = 4;
    localparam int BUD_W      = 7;
    localparam int DEF_W      = 10;
    localparam int COORD_W    = 34;
    localparam int SCORE_W    = 32;
    localparam int TAG_W      = 19;
    localparam int ADDR_W     = 3;

    localparam logic [LC_W-1:0]  LEVEL_COUNT_RST = 4'd8;
    localparam logic [BUD_W-1:0] BUDGET_RST      = 7'd8;

    // register indexes
    localparam logic REG_LEVEL_COUNT = 1'b0;
    localparam logic REG_BUDGET      = 1'b1;
endpackage
`default_nettype wire

// File: hw/rtl/klbs_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none
module klbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// File: hw/rtl/keypoint_level_budget_select_top.sv
// Keypoint level budget selector top level.
// Depends on klbs_pkg and klbs_ram.
//
// Keypoints of a cell load at one word per cycle into three 64-entry RAMs.
// After the word marked cell_end the block stops taking input: it works out
// per-level keep counts (one level at a time, highest first), then for each
// kept keypoint scans the buffer once through the RAM read port and presents
// it on the output register. Input is taken again after S_FINISH clears the
// buffer, which follows the last result of the cell being taken, or, when
// nothing survives, the keep-count pass (or cell_end itself at level count 0).
`default_nettype none
module keypoint_level_budget_select_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // configuration
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [klbs_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    // input words
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          has_point,
    input  wire logic [15:0]                   x_local,
    input  wire logic [15:0]                   y_local,
    input  wire logic [2:0]                    level,
    input  wire logic [31:0]                   response,
    input  wire logic [15:0]                   point_id,
    input  wire logic [11:0]                   x_offset,
    input  wire logic [11:0]                   y_offset,
    input  wire logic                          cell_end,
    // result words
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [16:0]                        x_global,
    output logic [16:0]                        y_global,
    output logic [2:0]                         out_level,
    output logic [31:0]                        out_response,
    output logic [15:0]                        out_id,
    output logic                               overflow,
    output logic                               last_of_cell
);
    import klbs_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_KEEP, S_LVL, S_SCAN, S_SWAIT, S_FETCH, S_LOAD, S_OUT, S_FINISH
    } state_t;

    state_t               state_reg;
    logic [LC_W-1:0]      level_count_reg;
    logic [BUD_W-1:0]     budget_reg;
    logic [CNT_W-1:0]     count_reg;
    logic                 ovf_reg;
    logic [CNT_W-1:0]     have_reg [MAX_LEVELS];
    logic [CNT_W-1:0]     keep_reg [MAX_LEVELS];
    logic [BUF_DEPTH-1:0] used_reg;
    logic [LC_W-1:0]      klvl_reg;
    logic [DEF_W-1:0]     deficit_reg;
    logic [CNT_W-1:0]     total_reg;
    logic [CNT_W-1:0]     emitted_reg;
    logic [CNT_W-1:0]     rem_reg;
    logic [LVL_W:0]       cur_lvl_reg;
    logic [IDX_W-1:0]     scan_idx_reg;
    logic                 pend_valid_reg;
    logic [IDX_W-1:0]     pend_idx_reg;
    logic                 found_reg;
    logic [IDX_W-1:0]     best_idx_reg;
    logic [SCORE_W-1:0]   best_score_reg;

    logic [LC_W-1:0]      eff_levels;
    logic                 in_acc;
    logic                 ram_we;
    logic [IDX_W-1:0]     raddr;
    logic [COORD_W-1:0]   coord_wdata, coord_rdata;
    logic [SCORE_W-1:0]   score_rdata;
    logic [TAG_W-1:0]     tag_wdata, tag_rdata;
    logic [16:0]          xg, yg;
    logic [LVL_W-1:0]     kl;
    logic [DEF_W-1:0]     target;

    // configuration port
    assign pready = 1'b1;
    always_comb
    begin
        prdata = '0;
        if (paddr == ADDR_W'(0))
            prdata = 32'(level_count_reg);
        else if (paddr == ADDR_W'(4))
            prdata = 32'(budget_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_count_reg <= LEVEL_COUNT_RST;
            budget_reg      <= BUDGET_RST;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr == {paddr[2], 2'b00} && paddr[2] == REG_LEVEL_COUNT)
                level_count_reg <= pwdata[LC_W-1:0];
            else if (paddr == {paddr[2], 2'b00} && paddr[2] == REG_BUDGET)
                budget_reg <= pwdata[BUD_W-1:0];
        end
    end

    assign eff_levels = (level_count_reg > LC_W'(MAX_LEVELS)) ? LC_W'(MAX_LEVELS)
                                                               : level_count_reg;

    // input side and buffer write
    assign in_ready    = (state_reg == S_IDLE);
    assign in_acc      = in_valid && in_ready;
    assign ram_we      = in_acc && has_point && (count_reg < CNT_W'(BUF_DEPTH));
    assign xg          = 17'(x_local) + {1'b0, x_offset, 4'b0000};
    assign yg          = 17'(y_local) + {1'b0, y_offset, 4'b0000};
    assign coord_wdata = {xg, yg};
    assign tag_wdata   = {level, point_id};
    assign raddr       = (state_reg == S_FETCH) ? best_idx_reg : scan_idx_reg;

    klbs_ram #(.WIDTH(COORD_W), .DEPTH(BUF_DEPTH)) u_coords (
        .clk(clk), .we(ram_we), .waddr(count_reg[IDX_W-1:0]), .wdata(coord_wdata),
        .raddr(raddr), .rdata(coord_rdata)
    );
    klbs_ram #(.WIDTH(SCORE_W), .DEPTH(BUF_DEPTH)) u_scores (
        .clk(clk), .we(ram_we), .waddr(count_reg[IDX_W-1:0]), .wdata(response),
        .raddr(raddr), .rdata(score_rdata)
    );
    klbs_ram #(.WIDTH(TAG_W), .DEPTH(BUF_DEPTH)) u_tags (
        .clk(clk), .we(ram_we), .waddr(count_reg[IDX_W-1:0]), .wdata(tag_wdata),
        .raddr(raddr), .rdata(tag_rdata)
    );

    assign kl     = LVL_W'(klvl_reg - LC_W'(1));
    assign target = DEF_W'(budget_reg) + deficit_reg;

    // sequencer: load, keep counts, scan per result, output
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            used_reg       <= '0;
            out_valid      <= 1'b0;
            pend_valid_reg <= 1'b0;
            pend_idx_reg   <= '0;
            found_reg      <= 1'b0;
            best_idx_reg   <= '0;
            best_score_reg <= '0;
            klvl_reg       <= '0;
            deficit_reg    <= '0;
            total_reg      <= '0;
            emitted_reg    <= '0;
            rem_reg        <= '0;
            cur_lvl_reg    <= '0;
            scan_idx_reg   <= '0;
            x_global       <= '0;
            y_global       <= '0;
            out_level      <= '0;
            out_response   <= '0;
            out_id         <= '0;
            overflow       <= 1'b0;
            last_of_cell   <= 1'b0;
            for (int i = 0; i < MAX_LEVELS; i++)
            begin
                have_reg[i] <= '0;
                keep_reg[i] <= '0;
            end
        end
        else
        begin
            // best-candidate compare on returning scan data
            if (pend_valid_reg && !used_reg[pend_idx_reg]
                && tag_rdata[TAG_W-1:16] == cur_lvl_reg[LVL_W-1:0]
                && (!found_reg || score_rdata > best_score_reg))
            begin
                found_reg      <= 1'b1;
                best_idx_reg   <= pend_idx_reg;
                best_score_reg <= score_rdata;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        if (has_point)
                        begin
                            if (count_reg < CNT_W'(BUF_DEPTH))
                            begin
                                count_reg       <= count_reg + CNT_W'(1);
                                have_reg[level] <= have_reg[level] + CNT_W'(1);
                            end
                            else
                                ovf_reg <= 1'b1;
                        end
                        if (cell_end)
                        begin
                            klvl_reg    <= eff_levels;
                            deficit_reg <= '0;
                            total_reg   <= '0;
                            emitted_reg <= '0;
                            state_reg   <= (eff_levels == '0) ? S_FINISH : S_KEEP;
                        end
                    end
                end
                S_KEEP:
                begin
                    if (DEF_W'(have_reg[kl]) > target)
                    begin
                        keep_reg[kl] <= CNT_W'(target);
                        total_reg    <= total_reg + CNT_W'(target);
                        deficit_reg  <= '0;
                    end
                    else
                    begin
                        keep_reg[kl] <= have_reg[kl];
                        total_reg    <= total_reg + have_reg[kl];
                        deficit_reg  <= target - DEF_W'(have_reg[kl]);
                    end
                    klvl_reg <= klvl_reg - LC_W'(1);
                    if (klvl_reg == LC_W'(1))
                    begin
                        cur_lvl_reg <= '0;
                        state_reg   <= S_LVL;
                    end
                end
                S_LVL:
                begin
                    if (total_reg == '0 || LC_W'(cur_lvl_reg) == eff_levels)
                        state_reg <= S_FINISH;
                    else if (keep_reg[cur_lvl_reg[LVL_W-1:0]] == '0)
                        cur_lvl_reg <= cur_lvl_reg + (LVL_W+1)'(1);
                    else
                    begin
                        rem_reg      <= keep_reg[cur_lvl_reg[LVL_W-1:0]];
                        scan_idx_reg <= '0;
                        found_reg    <= 1'b0;
                        state_reg    <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    pend_valid_reg <= 1'b1;
                    pend_idx_reg   <= scan_idx_reg;
                    if (CNT_W'(scan_idx_reg) == count_reg - CNT_W'(1))
                        state_reg <= S_SWAIT;
                    else
                        scan_idx_reg <= scan_idx_reg + IDX_W'(1);
                end
                S_SWAIT:
                begin
                    pend_valid_reg <= 1'b0;
                    state_reg      <= S_FETCH;
                end
                S_FETCH:
                begin
                    used_reg[best_idx_reg] <= 1'b1;
                    state_reg              <= S_LOAD;
                end
                S_LOAD:
                begin
                    x_global     <= coord_rdata[COORD_W-1:17];
                    y_global     <= coord_rdata[16:0];
                    out_level    <= tag_rdata[TAG_W-1:16];
                    out_response <= score_rdata;
                    out_id       <= tag_rdata[15:0];
                    overflow     <= ovf_reg;
                    last_of_cell <= (emitted_reg + CNT_W'(1) == total_reg);
                    emitted_reg  <= emitted_reg + CNT_W'(1);
                    out_valid    <= 1'b1;
                    state_reg    <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        out_valid <= 1'b0;
                        rem_reg   <= rem_reg - CNT_W'(1);
                        if (last_of_cell)
                            state_reg <= S_FINISH;
                        else if (rem_reg == CNT_W'(1))
                        begin
                            cur_lvl_reg <= cur_lvl_reg + (LVL_W+1)'(1);
                            state_reg   <= S_LVL;
                        end
                        else
                        begin
                            scan_idx_reg <= '0;
                            found_reg    <= 1'b0;
                            state_reg    <= S_SCAN;
                        end
                    end
                end
                S_FINISH:
                begin
                    count_reg <= '0;
                    ovf_reg   <= 1'b0;
                    used_reg  <= '0;
                    for (int i = 0; i < MAX_LEVELS; i++)
                        have_reg[i] <= '0;
                    state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: hw/rtl/klbs_checker.sv
// Port-level checks for the keypoint level budget selector, with bind.
// Depends on keypoint_level_budget_select_top.
`default_nettype none
module klbs_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        cell_end,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [31:0] out_response,
    input wire logic        last_of_cell
);
    // a pending result word holds until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_response))
        else $error("result word changed while stalled");

    // no input is taken while a result waits
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid)
        else $error("input ready with result pending");

    // cell end stops input for selection
    a_cell_end: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && cell_end |=> !in_ready)
        else $error("input taken right after cell end");

    // after the last word of a cell, no result follows at once
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last_of_cell |=> !out_valid)
        else $error("result after last of cell");
endmodule

bind keypoint_level_budget_select_top klbs_checker u_klbs_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .cell_end(cell_end), .out_valid(out_valid), .out_ready(out_ready),
    .out_response(out_response), .last_of_cell(last_of_cell)
);
`default_nettype wire

// File: verif/tb_keypoint_level_budget_select_top.sv
// Testbench for keypoint_level_budget_select_top: cell loads, per-level selection, carry.
// Depends on klbs_pkg and the RTL of the block; checks results against an inline predictor.
`timescale 1ns / 1ps
module tb_keypoint_level_budget_select_top;
    import klbs_pkg::*;

    localparam int NUM_REGS = 2;

    typedef struct packed {
        logic        has_point;
        logic [15:0] x_local;
        logic [15:0] y_local;
        logic [2:0]  level;
        logic [31:0] response;
        logic [15:0] point_id;
        logic [11:0] x_offset;
        logic [11:0] y_offset;
        logic        cell_end;
    } kp_word_t;

    typedef struct packed {
        logic [16:0] x_global;
        logic [16:0] y_global;
        logic [2:0]  level;
        logic [31:0] response;
        logic [15:0] id;
        logic        overflow;
        logic        last_of_cell;
    } kept_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_ready;
    kp_word_t drv = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    wire kept_word_t got;

    always #4 clk = ~clk;

    keypoint_level_budget_select_top u_top (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_ready(in_ready),
        .has_point(drv.has_point), .x_local(drv.x_local), .y_local(drv.y_local),
        .level(drv.level), .response(drv.response), .point_id(drv.point_id),
        .x_offset(drv.x_offset), .y_offset(drv.y_offset), .cell_end(drv.cell_end),
        .out_valid(out_valid), .out_ready(out_ready),
        .x_global(got.x_global), .y_global(got.y_global), .out_level(got.level),
        .out_response(got.response), .out_id(got.id), .overflow(got.overflow),
        .last_of_cell(got.last_of_cell)
    );

    // predictor state
    logic [3:0]  cfg_levels;
    logic [6:0]  cfg_budget;
    kept_word_t  cell_buf[BUF_DEPTH];
    int          cell_count;
    logic        cell_overflow;
    kept_word_t  kept_q[$];
    int          mismatches;

    // indices of buffered points of one level, strongest first, ties by arrival
    function automatic void rank_level(input int lvl, output int idx[$]);
        int pos;
        idx = {};
        for (int i = 0; i < cell_count; i++) begin
            if (cell_buf[i].level == lvl) begin
                pos = idx.size();
                while (pos > 0 && cell_buf[idx[pos-1]].response < cell_buf[i].response)
                    pos--;
                idx.insert(pos, i);
            end
        end
    endfunction

    task automatic predict_word(input kp_word_t w);
        int levels, deficit, target, produced;
        int keep[MAX_LEVELS];
        int idx[$];
        kept_word_t k;
        if (w.has_point) begin
            if (cell_count < BUF_DEPTH) begin
                k = '0;
                k.x_global = 17'(w.x_local) + 17'({w.x_offset, 4'b0});
                k.y_global = 17'(w.y_local) + 17'({w.y_offset, 4'b0});
                k.level = w.level;
                k.response = w.response;
                k.id = w.point_id;
                cell_buf[cell_count] = k;
                cell_count++;
            end else
                cell_overflow = 1'b1;
        end
        if (!w.cell_end) return;
        levels = cfg_levels > MAX_LEVELS ? MAX_LEVELS : cfg_levels;
        // keep counts, highest level first, unused budget carries down
        deficit = 0;
        for (int l = levels - 1; l >= 0; l--) begin
            target = cfg_budget + deficit;
            rank_level(l, idx);
            if (idx.size() > target) begin
                keep[l] = target;
                deficit = 0;
            end else begin
                keep[l] = idx.size();
                deficit = target - idx.size();
            end
        end
        produced = 0;
        for (int l = 0; l < levels; l++) begin
            rank_level(l, idx);
            for (int j = 0; j < keep[l] && produced < 64; j++) begin
                k = cell_buf[idx[j]];
                k.overflow = cell_overflow;
                k.last_of_cell = 1'b0;
                kept_q = {kept_q, k};
                produced++;
            end
        end
        if (produced > 0) kept_q[kept_q.size()-1].last_of_cell = 1'b1;
        cell_count = 0;
        cell_overflow = 1'b0;
    endtask

    // result checker
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (kept_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word %p", got);
            end else begin
                if (got !== kept_q[0]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p got %p", kept_q[0], got);
                end
                void'(kept_q.pop_front());
            end
        end
    end

    // receiver stall pattern
    int stall_mode = 0;
    always @(posedge clk) begin
        if (($urandom & 63) == 0) stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom & 3) != 0;
            default: out_ready <= ($urandom & 3) == 0;
        endcase
    end

    task automatic reg_write(input int idx, input logic [31:0] val);
        @(posedge clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_W'(4 * idx); pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (idx == REG_LEVEL_COUNT) cfg_levels = val[3:0];
        else cfg_budget = val[6:0];
    endtask

    // valid stays high inside a burst; it drops only for a gap
    int burst_left = 0;
    task automatic send_word(input kp_word_t w);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        in_valid <= 1'b1;
        drv <= w;
        do @(posedge clk); while (!in_ready);
        predict_word(w);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        while (kept_q.size() != 0 && guard < 200000) begin
            @(posedge clk);
            guard++;
        end
        // selection with no survivors may still be running
        repeat (300) @(posedge clk);
    endtask

    function automatic kp_word_t rand_point(input int lvl_hi, input logic end_flag);
        kp_word_t w;
        w.has_point = 1'b1;
        w.x_local = 16'($urandom);
        w.y_local = 16'($urandom);
        w.level = 3'($urandom_range(0, lvl_hi));
        // narrow response range makes ties common
        w.response = ($urandom & 1) ? $urandom : $urandom_range(0, 7);
        w.point_id = 16'($urandom);
        w.x_offset = 12'($urandom);
        w.y_offset = 12'($urandom);
        w.cell_end = end_flag;
        return w;
    endfunction

    // directed table: has_point, x, y, level, resp, id, xoff, yoff, end
    kp_word_t dir_tab[8] = '{
        '{1'b1, 16'hFFFF, 16'hFFFF, 3'd7, 32'hFFFFFFFF, 16'hFFFF, 12'hFFF, 12'hFFF, 1'b0},
        '{1'b1, 16'h0000, 16'h0000, 3'd0, 32'h0, 16'h0, 12'h0, 12'h0, 1'b0},
        '{1'b1, 16'h0010, 16'h0020, 3'd0, 32'd5, 16'd1, 12'd3, 12'd4, 1'b0},
        '{1'b1, 16'h0011, 16'h0021, 3'd0, 32'd5, 16'd2, 12'd3, 12'd4, 1'b0},
        '{1'b0, 16'h1234, 16'h5678, 3'd1, 32'd9, 16'd3, 12'd1, 12'd1, 1'b0},
        '{1'b1, 16'h0100, 16'h0200, 3'd3, 32'd100, 16'd4, 12'd7, 12'd8, 1'b1},
        '{1'b0, 16'h0, 16'h0, 3'd0, 32'd0, 16'd0, 12'd0, 12'd0, 1'b1},
        '{1'b1, 16'hAAAA, 16'h5555, 3'd2, 32'h80000000, 16'h5A5A, 12'hAAA, 12'h555, 1'b1}
    };
    // row 0 alone in a cell: typed-in expected word for the extreme case
    kept_word_t extreme_exp = '{17'h1FFEF, 17'h1FFEF, 3'd7, 32'hFFFFFFFF, 16'hFFFF, 1'b0, 1'b1};

    initial begin
        int sent, lc, bud, ncell;
        kp_word_t w;
        mismatches = 0;
        cfg_levels = LEVEL_COUNT_RST;
        cfg_budget = BUDGET_RST;
        cell_count = 0;
        cell_overflow = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // extreme single-point cell at reset config
        w = dir_tab[0];
        w.cell_end = 1'b1;
        send_word(w);
        if (kept_q.size() != 1 || kept_q[0] !== extreme_exp) begin
            mismatches++;
            if (mismatches <= 10) $display("extreme cell prediction off: %p", kept_q);
        end
        drain();
        foreach (dir_tab[i]) send_word(dir_tab[i]);
        drain();

        // overflow: 66 points into one cell, small budget
        reg_write(REG_BUDGET, 2);
        for (int i = 0; i < 66; i++) send_word(rand_point(7, i == 65));
        drain();

        // budget 0 everywhere, level count 0: nothing kept
        reg_write(REG_BUDGET, 0);
        send_word(rand_point(7, 1'b1));
        drain();
        reg_write(REG_LEVEL_COUNT, 0);
        reg_write(REG_BUDGET, 64);
        send_word(rand_point(7, 1'b1));
        drain();
        // level count above the cap
        reg_write(REG_LEVEL_COUNT, 15);
        for (int i = 0; i < 5; i++) send_word(rand_point(7, i == 4));
        drain();

        // random phases over several settings
        sent = 0;
        while (sent < 240) begin
            lc = $urandom_range(0, 4) == 0 ? $urandom_range(0, 15) : $urandom_range(1, 8);
            bud = $urandom_range(0, 3) == 0 ? ($urandom_range(0, 1) ? 0 : 64)
                                             : $urandom_range(0, 6);
            reg_write(REG_LEVEL_COUNT, lc);
            reg_write(REG_BUDGET, bud);
            for (int c = 0; c < 4; c++) begin
                ncell = $urandom_range(0, 9) == 0 ? $urandom_range(60, 70)
                                                  : $urandom_range(1, 12);
                for (int i = 0; i < ncell; i++) begin
                    if ($urandom_range(0, 9) == 0) begin
                        w = rand_point(7, i == ncell - 1);
                        w.has_point = 1'b0;
                    end else
                        w = rand_point(7, i == ncell - 1);
                    send_word(w);
                    sent++;
                end
            end
            drain();
        end

        if (mismatches == 0 && kept_q.size() == 0)
            $display("** keypoint_level_budget_select_top: PASSED **");
        else
            $display("** keypoint_level_budget_select_top: FAILED **");
        $finish;
    end

    initial begin
        #80ms;
        $display("** keypoint_level_budget_select_top: FAILED **");
        $finish;
    end
endmodule
